// ===== hdl/rau_pkg.sv =====
// rau_pkg: operation codes, status codes and widths for the rational arithmetic unit.
// No dependencies.
package rau_pkg;
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;
   localparam logic ST_OK  = 1'b0;
   localparam logic ST_ERR = 1'b1;
   localparam int NumWidth = 64;
   localparam int DenWidth = 62;
endpackage

// ===== hdl/rau_serial_unit.sv =====
// rau_serial_unit: bit-serial multiply (shift-add) and restoring divide on 64-bit words.
// Depends on rau_pkg.
module rau_serial_unit
   import rau_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic        is_div,
   input  logic [63:0] x,
   input  logic [63:0] y,
   output logic        done,
   output logic [63:0] q,
   output logic [63:0] r
);
   logic [63:0] acc_ff, acc_in, sh_ff, sh_in, y_ff, y_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in, div_ff, div_in, done_ff, done_in;
   logic [64:0] trial;

   always_comb begin
      acc_in = acc_ff; sh_in = sh_ff; y_in = y_ff; cnt_in = cnt_ff;
      run_in = run_ff; div_in = div_ff; done_in = 1'b0;
      trial = '0;
      if (go) begin
         acc_in = '0; sh_in = x; y_in = y; cnt_in = 7'd0; run_in = 1'b1; div_in = is_div;
      end else if (run_ff) begin
         if (div_ff) begin
            // restoring step: remainder in acc, quotient shifts into sh
            trial = {acc_ff, sh_ff[63]} - {1'b0, y_ff};
            if (!trial[64]) begin
               acc_in = trial[63:0]; sh_in = {sh_ff[62:0], 1'b1};
            end else begin
               acc_in = {acc_ff[62:0], sh_ff[63]}; sh_in = {sh_ff[62:0], 1'b0};
            end
         end else begin
            // shift-add: multiplier bits from sh lsb, multiplicand in y shifting left
            if (sh_ff[0]) acc_in = acc_ff + y_ff;
            sh_in = {1'b0, sh_ff[63:1]};
            y_in = {y_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in;
      end
      acc_ff <= acc_in; sh_ff <= sh_in; y_ff <= y_in; cnt_ff <= cnt_in; div_ff <= div_in;
   end

   assign done = done_ff;
   assign q = div_ff ? sh_ff : acc_ff;
   assign r = acc_ff;
endmodule

// ===== hdl/rational_arithmetic_unit_core.sv =====
// rational_arithmetic_unit_core: top level of the exact rational arithmetic unit.
// Depends on rau_pkg and rau_serial_unit.
//
// Usage: drive req_op and the two fractions and pulse start while busy is low;
// the item is taken on that edge and busy rises until the result is out.
// The result appears on rsp_res_num, rsp_res_den and rsp_status for exactly
// one cycle, marked by rsp_valid; the receiver cannot stall it.
// Errors (zero denominator, divide by zero) are caught in state S_CHK, which
// registers the error result and strobes rsp_valid without using the serial unit.
// Other items run a sequencer over one shared bit-serial unit that does a
// 64-step multiply or a 64-step restoring divide. Euclid's gcd repeats one
// modulo per iteration, so latency depends on the data: on the gcd iterations
// on the denominators for add and subtract (up to about 45) and on those on
// the result (up to about 90). A zero result (product or sum) skips the gcd
// and comes out as 0/1.
// Busy drops in the cycle the result is strobed, so one item is in flight.
// Reset (synchronous) returns the sequencer to idle and drops any item.
module rational_arithmetic_unit_core
   import rau_pkg::*;
#(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_op,
   input  logic [OPERAND_WIDTH-1:0]   req_a_num,
   input  logic [OPERAND_WIDTH-2:0]   req_a_den,
   input  logic [OPERAND_WIDTH-1:0]   req_b_num,
   input  logic [OPERAND_WIDTH-2:0]   req_b_den,
   output logic                       rsp_valid,
   output logic [NumWidth-1:0]        rsp_res_num,
   output logic [DenWidth-1:0]        rsp_res_den,
   output logic                       rsp_status
);
   localparam logic [4:0] S_IDLE = 5'd0,  S_CHK  = 5'd1,  S_G1   = 5'd2,  S_G1W  = 5'd3,
                          S_L1   = 5'd4,  S_L1W  = 5'd5,  S_TA   = 5'd6,  S_TAW  = 5'd7,
                          S_TB   = 5'd8,  S_TBW  = 5'd9,  S_ADD  = 5'd10, S_MA   = 5'd11,
                          S_MAW  = 5'd12, S_MB   = 5'd13, S_MBW  = 5'd14, S_G2   = 5'd15,
                          S_G2W  = 5'd16, S_RN   = 5'd17, S_RNW  = 5'd18, S_RD   = 5'd19,
                          S_RDW  = 5'd20, S_OUT  = 5'd21, S_L0   = 5'd22, S_L0W  = 5'd23;

   logic [4:0]  st_ff, st_in;
   logic [1:0]  op_ff, op_in;
   logic        an_ff, an_in, bn_ff, bn_in, neg_ff, neg_in;
   logic [63:0] am_ff, am_in, bm_ff, bm_in, ad_ff, ad_in, bd_ff, bd_in;
   logic [63:0] gx_ff, gx_in, gy_ff, gy_in, t_ff, t_in, m_ff, m_in, d_ff, d_in;
   logic        vld_ff, vld_in, err_ff, err_in;
   logic [63:0] on_ff, on_in;
   logic [61:0] od_ff, od_in;
   logic        go, is_div, sdone;
   logic [63:0] sx, sy, sq, sr;
   logic [OPERAND_WIDTH-1:0] ma, mb;

   rau_serial_unit u_ser (.clock, .reset, .go, .is_div, .x(sx), .y(sy),
                          .done(sdone), .q(sq), .r(sr));

   // magnitudes; the most negative value wraps to its own unsigned magnitude
   assign ma = req_a_num[OPERAND_WIDTH-1] ? (~req_a_num + OPERAND_WIDTH'(1)) : req_a_num;
   assign mb = req_b_num[OPERAND_WIDTH-1] ? (~req_b_num + OPERAND_WIDTH'(1)) : req_b_num;

   always_comb begin
      st_in = st_ff; op_in = op_ff; an_in = an_ff; bn_in = bn_ff; neg_in = neg_ff;
      am_in = am_ff; bm_in = bm_ff; ad_in = ad_ff; bd_in = bd_ff;
      gx_in = gx_ff; gy_in = gy_ff; t_in = t_ff; m_in = m_ff; d_in = d_ff;
      vld_in = 1'b0; err_in = err_ff; on_in = on_ff; od_in = od_ff;
      go = 1'b0; is_div = 1'b0; sx = '0; sy = '0;
      unique case (st_ff)
         S_IDLE: if (start) begin
            op_in = req_op;
            an_in = req_a_num[OPERAND_WIDTH-1];
            bn_in = req_b_num[OPERAND_WIDTH-1] ^ (req_op == OP_SUB);
            am_in = 64'(ma); bm_in = 64'(mb);
            ad_in = 64'(req_a_den); bd_in = 64'(req_b_den);
            st_in = S_CHK;
         end
         S_CHK: begin
            if (ad_ff == 0 || bd_ff == 0 || (op_ff == OP_DIV && bm_ff == 0)) begin
               err_in = ST_ERR; on_in = '0; od_in = '0; vld_in = 1'b1; st_in = S_IDLE;
            end else begin
               err_in = ST_OK;
               if (op_ff == OP_ADD || op_ff == OP_SUB) begin
                  gx_in = ad_ff; gy_in = bd_ff; st_in = S_G1;
               end else begin
                  neg_in = an_ff ^ bn_ff; st_in = S_MA;
               end
            end
         end
         // gcd of denominators: one modulo per visit
         S_G1: if (gx_ff == 0 || gy_ff == 0) begin
            t_in = gx_ff + gy_ff; st_in = S_L0;
         end else begin
            go = 1'b1; is_div = 1'b1;
            sx = (gx_ff > gy_ff) ? gx_ff : gy_ff;
            sy = (gx_ff > gy_ff) ? gy_ff : gx_ff;
            st_in = S_G1W;
         end
         S_G1W: if (sdone) begin
            if (gx_ff > gy_ff) gx_in = sr; else gy_in = sr;
            st_in = S_G1;
         end
         S_L0: begin go = 1'b1; is_div = 1'b1; sx = ad_ff; sy = t_ff; st_in = S_L0W; end
         S_L0W: if (sdone) begin t_in = sq; st_in = S_L1; end   // ad/g = l/bd, the scale of b
         S_L1: begin go = 1'b1; sx = t_ff; sy = bd_ff; st_in = S_L1W; end
         S_L1W: if (sdone) begin d_in = sr; st_in = S_TA; end   // lcm
         // ta = am * (bd/g); l/ad = bd/g; recompute from lcm/ad
         S_TA: begin go = 1'b1; is_div = 1'b1; sx = d_ff; sy = ad_ff; st_in = S_TAW; end
         S_TAW: if (sdone) begin
            go = 1'b1; sx = am_ff; sy = sq; st_in = S_TB;
         end
         S_TB: if (sdone) begin
            m_in = sr; go = 1'b1; is_div = 1'b1; sx = d_ff; sy = bd_ff; st_in = S_TBW;
         end
         S_TBW: if (sdone) begin go = 1'b1; sx = bm_ff; sy = sq; st_in = S_ADD; end
         S_ADD: if (sdone) begin
            if (an_ff == bn_ff) begin
               m_in = m_ff + sr; neg_in = an_ff;
            end else if (m_ff >= sr) begin
               m_in = m_ff - sr; neg_in = an_ff;
            end else begin
               m_in = sr - m_ff; neg_in = bn_ff;
            end
            st_in = S_G2;
            gx_in = m_in; gy_in = d_ff;
         end
         // multiply / divide cross products
         S_MA: begin
            go = 1'b1; sx = am_ff; sy = (op_ff == OP_MUL) ? bm_ff : bd_ff; st_in = S_MAW;
         end
         S_MAW: if (sdone) begin
            m_in = sr; go = 1'b1; sx = ad_ff; sy = (op_ff == OP_MUL) ? bd_ff : bm_ff;
            st_in = S_MB;
         end
         S_MB: if (sdone) begin d_in = sr; st_in = S_G2; gx_in = m_ff; gy_in = sr; end
         S_MBW: st_in = S_G2;
         // gcd of the result: one modulo per visit, then scale both parts down
         S_G2: if (m_ff == 0) begin
            on_in = '0; od_in = 62'd1; vld_in = 1'b1; st_in = S_IDLE;
         end else if (gx_ff == 0 || gy_ff == 0) begin
            t_in = gx_ff + gy_ff; st_in = S_RN;
         end else begin
            go = 1'b1; is_div = 1'b1;
            sx = (gx_ff > gy_ff) ? gx_ff : gy_ff;
            sy = (gx_ff > gy_ff) ? gy_ff : gx_ff;
            st_in = S_G2W;
         end
         S_G2W: if (sdone) begin
            if (gx_ff > gy_ff) gx_in = sr; else gy_in = sr;
            st_in = S_G2;
         end
         S_RN: begin go = 1'b1; is_div = 1'b1; sx = m_ff; sy = t_ff; st_in = S_RNW; end
         S_RNW: if (sdone) begin
            m_in = sq; go = 1'b1; is_div = 1'b1; sx = d_ff; sy = t_ff; st_in = S_RD;
         end
         S_RD: if (sdone) begin d_in = sq; st_in = S_OUT; end
         S_RDW: st_in = S_OUT;
         S_OUT: begin
            on_in = neg_ff ? (~m_ff + 64'd1) : m_ff; od_in = d_ff[61:0];
            vld_in = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; vld_ff <= 1'b0;
      end else begin
         st_ff <= st_in; vld_ff <= vld_in;
      end
      op_ff <= op_in; an_ff <= an_in; bn_ff <= bn_in; neg_ff <= neg_in;
      am_ff <= am_in; bm_ff <= bm_in; ad_ff <= ad_in; bd_ff <= bd_in;
      gx_ff <= gx_in; gy_ff <= gy_in; t_ff <= t_in; m_ff <= m_in; d_ff <= d_in;
      err_ff <= err_in; on_ff <= on_in; od_ff <= od_in;
   end

   assign busy = (st_ff != S_IDLE);
   assign rsp_valid = vld_ff;
   assign rsp_res_num = on_ff;
   assign rsp_res_den = od_ff;
   assign rsp_status = err_ff;
endmodule

// ===== hdl/rau_checker.sv =====
// rau_checker: port-level assertions for rational_arithmetic_unit_core, bound below.
// Depends on rau_pkg.
module rau_checker
   import rau_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [63:0] rsp_res_num,
   input logic [61:0] rsp_res_den,
   input logic        rsp_status
);
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_res_num == 0 && rsp_res_den == 0)
      else $error("error result not zero");
   a_ok_den: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_status |-> rsp_res_den != 0)
      else $error("zero denominator on ok result");
   a_take: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("item not taken");
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("repeated result");
endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (
   .clock, .reset, .start, .busy, .rsp_valid, .rsp_res_num, .rsp_res_den, .rsp_status);

// ===== tb/tb_rational_arithmetic_unit_core.sv =====
// Self-checking bench for rational_arithmetic_unit_core: directed table plus random items,
// each checked against a typed-in value or the reducer here. Depends on rau_pkg and the RTL.
module tb_rational_arithmetic_unit_core;
   timeunit 1ns;
   timeprecision 1ps;
   import rau_pkg::*;

   localparam int W = 32;
   localparam int WATCHDOG = 40000;

   typedef struct {
      logic [NumWidth-1:0] num;
      logic [DenWidth-1:0] den;
      logic                status;
   } frac_type;

   typedef struct {
      logic [1:0]   op;
      logic [W-1:0] an;
      logic [W-2:0] ad;
      logic [W-1:0] bn;
      logic [W-2:0] bd;
      bit           fixed;   // expected value typed in below
      frac_type     want;
   } row_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            start = 1'b0;
   logic            busy;
   logic [1:0]      req_op = OP_ADD;
   logic [W-1:0]    req_a_num = '0;
   logic [W-2:0]    req_a_den = '0;
   logic [W-1:0]    req_b_num = '0;
   logic [W-2:0]    req_b_den = '0;
   logic            rsp_valid;
   logic [NumWidth-1:0] rsp_res_num;
   logic [DenWidth-1:0] rsp_res_den;
   logic            rsp_status;

   frac_type pending_fracs[$];
   int    errors = 0;
   int    idle_cycles = 0;
   int    gap_pct = 0;

   always #1 clock = ~clock;

   rational_arithmetic_unit_core #(.OPERAND_WIDTH(W)) dut (.*);

   function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
      while (x != 0 && y != 0) begin
         if (x > y) x = x % y;
         else y = y % x;
      end
      return x + y;
   endfunction

   // Reduce mag/den, put the sign on the numerator; zero becomes 0/1.
   function automatic frac_type reduce(bit neg, logic [63:0] mag, logic [63:0] den);
      frac_type f;
      logic [63:0] g;
      if (mag == 0) begin
         f.num = '0; f.den = 1; f.status = ST_OK;
         return f;
      end
      g = gcd64(mag, den);
      mag = mag / g;
      den = den / g;
      f.num = neg ? -mag : mag;
      f.den = den[DenWidth-1:0];
      f.status = ST_OK;
      return f;
   endfunction

   function automatic frac_type rational_result(logic [1:0] op, logic [W-1:0] an,
         logic [W-2:0] ad, logic [W-1:0] bn, logic [W-2:0] bd);
      frac_type f;
      bit a_neg, b_neg;
      logic [W-1:0] an_mag, bn_mag;
      logic [63:0] am, bm, g, l, ta, tb;
      a_neg = an[W-1];
      b_neg = bn[W-1];
      an_mag = -an;   // most negative value keeps its magnitude
      bn_mag = -bn;
      am = a_neg ? 64'(an_mag) : 64'(an);
      bm = b_neg ? 64'(bn_mag) : 64'(bn);
      if (ad == 0 || bd == 0 || (op == OP_DIV && bm == 0)) begin
         f.num = '0; f.den = '0; f.status = ST_ERR;
         return f;
      end
      if (op == OP_SUB) b_neg = !b_neg;
      case (op)
         OP_ADD, OP_SUB: begin
            g = gcd64(ad, bd);
            l = (ad / g) * bd;
            ta = am * (l / ad);
            tb = bm * (l / bd);
            if (a_neg == b_neg) f = reduce(a_neg, ta + tb, l);
            else if (ta >= tb) f = reduce(a_neg, ta - tb, l);
            else f = reduce(b_neg, tb - ta, l);
         end
         OP_MUL: f = reduce(a_neg != b_neg, am * bm, 64'(ad) * bd);
         default: f = reduce(a_neg != b_neg, am * 64'(bd), 64'(ad) * bm);
      endcase
      return f;
   endfunction

   // Hold start until the item is taken; leave it high so the next item can follow
   // at once, and drop it only for a gap.
   task automatic issue(logic [1:0] op, logic [W-1:0] an, logic [W-2:0] ad,
         logic [W-1:0] bn, logic [W-2:0] bd, bit fixed, frac_type want);
      frac_type f;
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      f = fixed ? want : rational_result(op, an, ad, bn, bd);
      start <= 1'b1;
      req_op <= op; req_a_num <= an; req_a_den <= ad;
      req_b_num <= bn; req_b_den <= bd;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_fracs.insert(pending_fracs.size(), f);
   endtask

   // Random operands: half the numerators, most denominators small to keep gcd loops short.
   function automatic logic [W-1:0] rnd_num();
      case ($urandom_range(5))
         0: return $urandom;
         1: return {1'b1, {(W-1){1'b0}}};
         2: return $urandom_range(1, 0) ? 32'h7fffffff : 32'h80000001;
         default: return W'($signed($urandom_range(2000)) - 1000);
      endcase
   endfunction

   function automatic logic [W-2:0] rnd_den();
      case ($urandom_range(7))
         0: return (W-1)'($urandom);
         1: return '1;
         2: return '0;
         default: return (W-1)'($urandom_range(1, 500));
      endcase
   endfunction

   // Check every strobed result against the oldest expectation.
   always @(posedge clock) begin
      frac_type e;
      if (!reset && rsp_valid) begin
         if (pending_fracs.size() == 0) begin
            $display("%0t: result with nothing expected: %0d/%0d st %0b", $time,
                     $signed(rsp_res_num), rsp_res_den, rsp_status);
            errors++;
         end else begin
            e = pending_fracs.pop_front();
            if (rsp_res_num !== e.num) begin
               $display("%0t: num expected %0d got %0d", $time, $signed(e.num),
                        $signed(rsp_res_num));
               errors++;
            end
            if (rsp_res_den !== e.den) begin
               $display("%0t: den expected %0d got %0d", $time, e.den, rsp_res_den);
               errors++;
            end
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0b got %0b", $time, e.status, rsp_status);
               errors++;
            end
         end
      end
   end

   // Watchdog: count cycles in which neither an item nor a result is accepted.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   localparam frac_type ERR = '{num: '0, den: '0, status: ST_ERR};
   localparam frac_type ZERO = '{num: '0, den: 1, status: ST_OK};
   localparam frac_type NONE = '{num: '0, den: '0, status: ST_OK};

   row_type directed[] = '{
      '{OP_ADD, 32'd1, 31'd0, 32'd1, 31'd1, 1, ERR},        // zero denominator on a
      '{OP_MUL, 32'd1, 31'd3, 32'd1, 31'd0, 1, ERR},        // zero denominator on b
      '{OP_DIV, 32'd5, 31'd7, 32'd0, 31'd9, 1, ERR},        // divide by zero
      '{OP_SUB, 32'd0, 31'd0, 32'd0, 31'd0, 1, ERR},
      '{OP_ADD, 32'd0, 31'd5, 32'd0, 31'd7, 1, ZERO},       // zero is 0/1
      '{OP_SUB, 32'd3, 31'd4, 32'd3, 31'd4, 1, ZERO},
      '{OP_MUL, 32'd0, 31'h7fffffff, 32'h80000000, 31'd1, 1, ZERO},
      '{OP_ADD, 32'd1, 31'd2, 32'd1, 31'd3, 0, NONE},
      '{OP_SUB, 32'd1, 31'd2, 32'd1, 31'd3, 0, NONE},
      '{OP_MUL, 32'hfffffffe, 31'd3, 32'd3, 31'd4, 0, NONE},
      '{OP_DIV, 32'd2, 31'd3, 32'hfffffffd, 31'd4, 0, NONE},
      '{OP_ADD, 32'h80000000, 31'h7fffffff, 32'h80000000, 31'h7ffffffe, 0, NONE},
      '{OP_SUB, 32'h7fffffff, 31'h7fffffff, 32'h80000000, 31'h7ffffffe, 0, NONE},
      '{OP_MUL, 32'h80000000, 31'h7fffffff, 32'h80000000, 31'h7ffffffd, 0, NONE},
      '{OP_DIV, 32'h80000000, 31'd1, 32'h80000001, 31'h7fffffff, 0, NONE},
      '{OP_DIV, 32'h7fffffff, 31'h7fffffff, 32'h80000001, 31'd1, 0, NONE},
      '{OP_MUL, 32'h80000001, 31'd1, 32'h7fffffff, 31'd1, 0, NONE},
      '{OP_ADD, 32'h7fffffff, 31'd1, 32'h7fffffff, 31'd1, 0, NONE},
      '{OP_SUB, 32'h80000000, 31'd1, 32'h7fffffff, 31'd1, 0, NONE},
      '{OP_ADD, 32'd6, 31'd4, 32'd10, 31'd6, 0, NONE},
      '{OP_DIV, 32'hffffffff, 31'd1, 32'hffffffff, 31'd1, 0, NONE}
   };

   initial begin
      int n;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         issue(directed[i].op, directed[i].an, directed[i].ad, directed[i].bn,
               directed[i].bd, directed[i].fixed, directed[i].want);

      // Random phases: no gaps, sender gaps 54 of 100, then 15 of 100.
      for (n = 0; n < 540; n++) begin
         gap_pct = (n < 180) ? 0 : (n < 360) ? 54 : 15;
         // Hold off once until the unit has drained every pending result.
         if (n == 270) begin
            start <= 1'b0;
            while (pending_fracs.size() != 0) @(posedge clock);
         end
         issue(2'($urandom_range(3)), rnd_num(), rnd_den(), rnd_num(), rnd_den(), 0, NONE);
      end

      start <= 1'b0;
      while (pending_fracs.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule

// ===== files.f =====
hdl/rau_pkg.sv
hdl/rau_serial_unit.sv
hdl/rational_arithmetic_unit_core.sv
hdl/rau_checker.sv
tb/tb_rational_arithmetic_unit_core.sv
